// ===== src/tkts_pkg.sv =====
// Package for the top-k temperature sampler.
// Holds payload structs, config register indexes and the exp weight table function.
// Used by tkts_exp_table and top_k_temperature_sampler_top.
package tkts_pkg;

    typedef struct packed {
        logic signed [15:0] logit;
        logic [15:0]        random_draw;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic [11:0] token_index;
        logic        was_greedy;
    } out_item_t;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_K = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TEMP = 1'd1;

    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748381;
    localparam logic [63:0] WEIGHT_ONE = 64'd2147483648;

    // Entry i of the Q1.31 exponential table, exp(-i/16), built by recurrence.
    function automatic logic [31:0] exp_entry(input int unsigned idx);
        logic [63:0] e;
        e = WEIGHT_ONE;
        for (int unsigned j = 1; j <= idx; j++)
        begin
            e = ((e * EXP_STEP_Q32) + WEIGHT_ONE) >> 32;
        end
        return e[31:0];
    endfunction

endpackage

// ===== src/top_k_temperature_sampler_top.sv =====
// Top-k sampler with temperature. Depends on tkts_pkg and tkts_exp_table.
// Stored request: IRD, ILRD, ICMP per entry compared, then DONE; an empty ranking goes to DONE.
// Last request: DONE again, then WRD, WLRD (greedy) or WRD..SRD per kept entry, then SCMP scan.
// Throughput: one request at a time; ready again once the FSM is back in idle.
// A pending result holds the FSM only once the next result is ready; until then input is taken.
// Reset: asynchronous active low; clears control, entry count, running max; config to top_k 0, inv 256.
module top_k_temperature_sampler_top #(
    parameter int VOCAB_MAX = 4096,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tkts_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output tkts_pkg::out_item_t              out_data,
    input  logic                             cfg_we,
    input  logic [tkts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tkts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tkts_pkg::*;

    localparam int AW = $clog2(VOCAB_MAX);
    localparam int CW = AW + 1;
    localparam int SUM_W = 32 + CW;
    localparam int TGT_W = SUM_W + 16;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_IRD    = 11'b00000000010,
        ST_ILRD   = 11'b00000000100,
        ST_ICMP   = 11'b00000001000,
        ST_DONE   = 11'b00000010000,
        ST_WRD    = 11'b00000100000,
        ST_WLRD   = 11'b00001000000,
        ST_WMUL   = 11'b00010000000,
        ST_WEXP   = 11'b00100000000,
        ST_SRD    = 11'b01000000000,
        ST_SCMP   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Memories
    logic [15:0] logit_mem [VOCAB_MAX];
    logic [AW-1:0] rank_mem [VOCAB_MAX];
    logic [31:0] weight_mem [VOCAB_MAX];

    logic [15:0] logit_rd;
    logic [AW-1:0] rank_rd;
    logic [31:0] weight_rd;

    logic [12:0] top_k_reg;
    logic [15:0] inv_temp_reg;
    logic [CW-1:0] count_reg, count_next;
    logic signed [15:0] max_reg, max_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] kept_reg, kept_next;
    in_item_t item_reg, item_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [TGT_W-1:0] tgt_reg, tgt_next;
    logic [31:0] prod_reg;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic stored_reg, stored_next;

    // Memory control
    logic [AW-1:0] lg_raddr, rk_raddr, rk_waddr, lg_waddr, wt_addr;
    logic rk_we, lg_we, wt_we;
    logic [AW-1:0] rk_wdata;
    logic [31:0] exp_w;

    always_ff @(posedge clk)
    begin
        if (lg_we)
            logit_mem[lg_waddr] <= item_reg.logit;
        logit_rd <= logit_mem[lg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
            rank_mem[rk_waddr] <= rk_wdata;
        rank_rd <= rank_mem[rk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
            weight_mem[wt_addr] <= exp_w;
        weight_rd <= weight_mem[wt_addr];
    end

    // Distance times inverse temperature, registered.
    logic [15:0] gap;
    assign gap = 16'(max_reg - $signed(logit_rd));
    always_ff @(posedge clk)
    begin
        prod_reg <= gap * inv_temp_reg;
    end

    logic [20:0] exp_idx;
    assign exp_idx = 21'(({1'b0, prod_reg} + 33'd2048) >> 12);

    tkts_exp_table #(.DEPTH(EXP_TABLE_DEPTH), .IDX_W(21)) u_exp (
        .clk    (clk),
        .idx    (exp_idx),
        .weight (exp_w)
    );

    logic in_fire, out_fire, out_free;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    logic [CW-1:0] pm1;
    assign pm1 = pos_reg - CW'(1);

    // Running cumulative weight during the scan
    logic [SUM_W-1:0] cum_sum;
    assign cum_sum = sum_reg + SUM_W'(weight_rd);

    // Control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        max_next = max_reg;
        pos_next = pos_reg;
        kept_next = kept_reg;
        item_next = item_reg;
        sum_next = sum_reg;
        tgt_next = tgt_reg;
        out_valid_next = out_valid_reg && !out_fire;
        out_next = out_reg;
        stored_next = stored_reg;
        lg_raddr = rank_rd;
        rk_raddr = pm1[AW-1:0];
        rk_waddr = pos_reg[AW-1:0];
        rk_wdata = rank_rd;
        lg_waddr = count_reg[AW-1:0];
        wt_addr = pos_reg[AW-1:0];
        rk_we = 1'b0;
        lg_we = 1'b0;
        wt_we = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_next = in_data;
                    pos_next = count_reg;
                    stored_next = count_reg < CW'(VOCAB_MAX);
                    if (count_reg < CW'(VOCAB_MAX))
                        state_next = (count_reg == '0) ? ST_DONE : ST_IRD;
                    else
                        state_next = in_data.is_last ? ST_DONE : ST_IDLE;
                end
            end
            ST_IRD:
                state_next = ST_ILRD;  // rank at pos-1 arriving
            ST_ILRD:
                state_next = ST_ICMP;  // logit of that rank arriving
            ST_ICMP:
            begin
                if ($signed(logit_rd) < item_reg.logit)
                begin
                    rk_we = 1'b1;
                    pos_next = pm1;
                    rk_raddr = AW'(pm1 - CW'(1));
                    state_next = (pm1 == '0) ? ST_DONE : ST_IRD;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stored_reg)
                begin
                    rk_we = 1'b1;
                    rk_wdata = count_reg[AW-1:0];
                    lg_we = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (item_reg.logit > max_reg)
                        max_next = item_reg.logit;
                    stored_next = 1'b0;
                end
                if (!item_reg.is_last)
                    state_next = ST_IDLE;
                else if (!stored_reg)
                begin
                    kept_next = (top_k_reg == '0 || 14'(top_k_reg) > 14'(count_reg))
                        ? count_reg : CW'(top_k_reg);
                    pos_next = '0;
                    sum_next = '0;
                    rk_raddr = '0;
                    state_next = ST_WRD;
                end
            end
            ST_WRD:
            begin
                rk_raddr = pos_reg[AW-1:0];
                state_next = ST_WLRD;
            end
            ST_WLRD:
            begin
                // hold the rank read while a greedy result waits for the slot
                rk_raddr = pos_reg[AW-1:0];
                if (inv_temp_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_next.token_index = 12'(rank_rd);
                        out_next.was_greedy = 1'b1;
                        out_valid_next = 1'b1;
                        count_next = '0;
                        max_next = -16'sd32768;
                        state_next = ST_IDLE;
                    end
                end
                else
                    state_next = ST_WMUL;
            end
            ST_WMUL:
                state_next = ST_WEXP;
            ST_WEXP:
                state_next = ST_SRD;
            ST_SRD:
            begin
                // weight now valid: store and accumulate
                wt_we = 1'b1;
                sum_next = sum_reg + SUM_W'(exp_w);
                if (pos_reg + CW'(1) < kept_reg)
                begin
                    pos_next = pos_reg + CW'(1);
                    state_next = ST_WRD;
                end
                else
                begin
                    tgt_next = TGT_W'(item_reg.random_draw) * TGT_W'(sum_reg + SUM_W'(exp_w));
                    sum_next = '0;
                    pos_next = '0;
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                // loop of a read phase (rank and weight), then a compare phase
                rk_raddr = pos_reg[AW-1:0];
                if (stored_reg)
                begin
                    if (tgt_reg <= (TGT_W'(cum_sum) << 16) || pos_reg + CW'(1) == kept_reg)
                    begin
                        // first rank reaching the target, else the last kept one
                        if (out_free)
                        begin
                            out_next.token_index = 12'(rank_rd);
                            out_next.was_greedy = 1'b0;
                            out_valid_next = 1'b1;
                            count_next = '0;
                            max_next = -16'sd32768;
                            stored_next = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        sum_next = cum_sum;
                        pos_next = pos_reg + CW'(1);
                        stored_next = 1'b0;
                    end
                end
                else
                    stored_next = 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            max_reg <= -16'sd32768;
            out_valid_reg <= 1'b0;
            stored_reg <= 1'b0;
            top_k_reg <= '0;
            inv_temp_reg <= 16'd256;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            max_reg <= max_next;
            out_valid_reg <= out_valid_next;
            stored_reg <= stored_next;
            if (cfg_we && cfg_index == CFG_TOP_K)
                top_k_reg <= cfg_data[12:0];
            if (cfg_we && cfg_index == CFG_INV_TEMP)
                inv_temp_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        kept_reg <= kept_next;
        item_reg <= item_next;
        sum_reg <= sum_next;
        tgt_reg <= tgt_next;
        out_reg <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while waiting");
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
endmodule

// ===== src/tkts_exp_table.sv =====
// Registered exponential weight table lookup.
// Depends on tkts_pkg for the table entries.
module tkts_exp_table #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 30
) (
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    output logic [31:0]      weight
);
    import tkts_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [31:0] rom [DEPTH];

    // Table contents fixed at elaboration.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        assign rom[g] = exp_entry(g);
    end

    // Out of range reads give zero weight.
    always_ff @(posedge clk)
    begin
        if (idx < IDX_W'(DEPTH))
            weight <= rom[idx[AW-1:0]];
        else
            weight <= '0;
    end
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for top_k_temperature_sampler_top.
// Depends on tkts_pkg. Loads logit vectors, predicts each sampled token and
// checks it, with random request gaps, output stalls and config changes.
module tb_top;
    import tkts_pkg::*;

    localparam int VOCAB = 4096;
    localparam int EXP_DEPTH = 256;
    localparam int STALL_LIMIT = 200000;
    localparam int SETTLE = 40;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    top_k_temperature_sampler_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Stimulus and expected tokens
    in_item_t pending_reqs[$];
    out_item_t tokens_due[$];
    int fails = 0;
    int vectors_sent = 0;
    int tokens_seen = 0;
    int greedy_seen = 0;
    int cycle_cnt = 0;
    logic req_taken;

    // Shadow of the sampler state and config
    longint unsigned exp_weight[EXP_DEPTH];
    logic signed [15:0] shadow_logit[VOCAB];
    int unsigned shadow_rank[VOCAB];
    longint unsigned shadow_weight[VOCAB];
    int unsigned shadow_count;
    logic signed [15:0] shadow_max;
    int unsigned cur_top_k;
    int unsigned cur_inv_temp;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic bit quiet_window();
        return cycle_cnt > 12000 && cycle_cnt < 20000;
    endfunction

    // Insert one logit into the ranking; on the last one predict the token.
    function automatic void sample_step(in_item_t it);
        int unsigned pos;
        int unsigned kept;
        int unsigned chosen;
        longint unsigned gap;
        longint unsigned idx;
        longint unsigned total;
        longint unsigned cum;
        longint unsigned goal;
        out_item_t tok;
        if (shadow_count < VOCAB)
        begin
            pos = shadow_count;
            while (pos > 0 && shadow_logit[shadow_rank[pos-1]] < it.logit)
            begin
                shadow_rank[pos] = shadow_rank[pos-1];
                pos--;
            end
            shadow_rank[pos] = shadow_count;
            shadow_logit[shadow_count] = it.logit;
            shadow_count++;
            if (it.logit > shadow_max)
                shadow_max = it.logit;
        end
        if (!it.is_last)
            return;
        kept = (cur_top_k == 0 || cur_top_k > shadow_count) ? shadow_count : cur_top_k;
        tok.was_greedy = 1'b0;
        if (cur_inv_temp == 0)
        begin
            chosen = shadow_rank[0];
            tok.was_greedy = 1'b1;
        end
        else
        begin
            total = 0;
            for (int r = 0; r < kept; r++)
            begin
                gap = longint'(int'(shadow_max) - int'(shadow_logit[shadow_rank[r]]));
                idx = (gap * cur_inv_temp + 2048) >> 12;
                shadow_weight[r] = (idx < EXP_DEPTH) ? exp_weight[idx] : 0;
                total += shadow_weight[r];
            end
            goal = longint'(it.random_draw) * total;
            chosen = shadow_rank[kept-1];
            cum = 0;
            for (int r = 0; r < kept; r++)
            begin
                cum += shadow_weight[r];
                if (goal <= (cum << 16))
                begin
                    chosen = shadow_rank[r];
                    break;
                end
            end
        end
        tok.token_index = chosen[11:0];
        tokens_due = {tokens_due, tok};
        shadow_count = 0;
        shadow_max = -16'sd32768;
    endfunction

    // Request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (pending_reqs.size() > 0 && (quiet_window() || $urandom_range(99) >= 28))
            begin
                in_data <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Request monitor feeds the predictor
    always @(posedge clk)
    begin
        req_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            sample_step(in_data);
    end

    // Receiver with random stalls and long hold-offs
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (cycle_cnt == 3000 || cycle_cnt == 40000)
            hold_left = 600;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= quiet_window() || $urandom_range(99) >= 28;
        end
    end

    // Token checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("unexpected token %0d", out_data.token_index);
                fails++;
            end
            else
            begin
                out_item_t want;
                want = tokens_due.pop_front();
                tokens_seen++;
                if (want.was_greedy)
                    greedy_seen++;
                if (out_data.token_index !== want.token_index)
                begin
                    $error("token_index expected %0d actual %0d",
                           want.token_index, out_data.token_index);
                    fails++;
                end
                if (out_data.was_greedy !== want.was_greedy)
                begin
                    $error("was_greedy expected %0d actual %0d",
                           want.was_greedy, out_data.was_greedy);
                    fails++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    int stall_cnt = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic in_item_t make_req(logic signed [15:0] lg, logic [15:0] dr, logic lst);
        in_item_t it;
        it.logit = lg;
        it.random_draw = dr;
        it.is_last = lst;
        return it;
    endfunction

    function automatic logic [15:0] pick_draw();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random vector: style 0 full range, 1 narrow range with ties, 2 extremes
    task automatic queue_vector(int len, int style);
        logic signed [15:0] lg;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: lg = 16'($urandom);
                1: lg = 16'(int'($urandom_range(8)) - 4) <<< $urandom_range(6);
                default: lg = $urandom_range(1) ? 16'sh7FFF - 16'($urandom_range(3))
                                                : -16'sd32768 + 16'($urandom_range(3));
            endcase
            pending_reqs = {pending_reqs, make_req(lg, pick_draw(), i == len - 1)};
        end
        vectors_sent++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() > 0 || in_valid || tokens_due.size() > 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        if (idx == CFG_TOP_K)
            cur_top_k = val & 16'h1FFF;
        else
            cur_inv_temp = val & 16'hFFFF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(int unsigned k, int unsigned inv);
        wait_idle();
        write_cfg(CFG_TOP_K, k);
        write_cfg(CFG_INV_TEMP, inv);
    endtask

    initial
    begin
        int unsigned k;
        int unsigned inv;
        int sent;
        // Exponential weight table, Q1.31
        exp_weight[0] = 64'd2147483648;
        for (int i = 1; i < EXP_DEPTH; i++)
            exp_weight[i] = (exp_weight[i-1] * 64'd4034748381 + 64'd2147483648) >> 32;
        shadow_count = 0;
        shadow_max = -16'sd32768;
        cur_top_k = 0;
        cur_inv_temp = 256;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset config, extremes, single item, ties, draw ends
        pending_reqs = {pending_reqs, make_req(16'sh7FFF, 16'd0, 1'b0)};
        pending_reqs = {pending_reqs, make_req(-16'sd32768, 16'hFFFF, 1'b1)};
        pending_reqs = {pending_reqs, make_req(16'sd0, 16'hFFFF, 1'b1)};
        pending_reqs = {pending_reqs, make_req(16'sd5, 16'd0, 1'b0)};
        pending_reqs = {pending_reqs, make_req(16'sd5, 16'd0, 1'b0)};
        pending_reqs = {pending_reqs, make_req(16'sd5, 16'hFFFF, 1'b1)};
        vectors_sent += 3;
        set_cfg(0, 0);      // greedy
        pending_reqs = {pending_reqs, make_req(16'sd3, 16'h1234, 1'b0)};
        pending_reqs = {pending_reqs, make_req(16'sd9, 16'h1234, 1'b0)};
        pending_reqs = {pending_reqs, make_req(16'sd9, 16'h1234, 1'b1)};
        vectors_sent++;
        set_cfg(1, 65535);
        queue_vector(6, 0);
        set_cfg(4096, 1);
        queue_vector(8, 1);
        set_cfg(2, 256);
        queue_vector(5, 2);

        // Random vectors, config changed every 8 vectors
        sent = 0;
        while (sent < 1450)
        begin
            case ($urandom_range(5))
                0: k = 0;
                1: k = 1;
                2: k = 4096;
                default: k = $urandom_range(30);
            endcase
            case ($urandom_range(5))
                0: inv = 0;
                1: inv = 65535;
                2: inv = $urandom_range(1, 16);
                default: inv = $urandom_range(1, 65535);
            endcase
            set_cfg(k, inv);
            for (int v = 0; v < 8; v++)
            begin
                int len;
                len = ($urandom_range(15) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
                queue_vector(len, $urandom_range(2));
                sent += len;
            end
        end

        wait_idle();
        $display("covered %0d vectors, %0d tokens checked (%0d greedy)",
                 vectors_sent, tokens_seen, greedy_seen);
        $display("configs swept top_k 0..4096, inv_temperature 0..65535, with output hold-offs");
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== top_k_temperature_sampler_top.f =====
src/tkts_pkg.sv
src/tkts_exp_table.sv
src/top_k_temperature_sampler_top.sv
tb/tb_top.sv
